// ===== rtl/ptpp_pkg.sv =====
`timescale 1ns / 1ps
package ptpp_pkg;

	// one input beat: a point in Q16.16
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	// one result beat
	typedef struct packed {
		logic signed [31:0] proj_x;
		logic signed [31:0] proj_y;
		logic signed [31:0] proj_z;
		logic signed [31:0] signed_distance;
		logic signed [15:0] out_normal_x;
		logic signed [15:0] out_normal_y;
		logic        [14:0] out_normal_z;
		logic        [1:0]  status;
	} result_t;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_NX = 2'd0;
	localparam logic [1:0] REG_NY = 2'd1;
	localparam logic [1:0] REG_NZ = 2'd2;
	localparam logic [1:0] REG_D  = 2'd3;

	// quotient bits of the displacement divide (clamped, saturates beyond)
	localparam int DQ_BITS = 34;
	// quotient bits of num^2 / nn (clamped, distance saturates beyond)
	localparam int SQ_BITS = 63;
	// root bits of the distance square root
	localparam int RT_BITS = 32;

endpackage

// ===== rtl/point_to_plane_projection.sv =====
`timescale 1ns / 1ps
// Orthogonal projection of a Q16.16 point onto the plane n . p = d.
// Configuration: APB-style port, 32-bit data. Registers at byte addresses
// 0x0 normal_x, 0x4 normal_y, 0x8 normal_z, 0xC plane_offset. pready is
// always high; a write lands at the access cycle edge. Reset loads
// normal = (0, 0, 1.0) and d = 0. Write registers only while no point is
// in flight.
// Input: a point is taken at every edge where start is high; busy is
// always low, so one point per clock cycle is sustained.
// Output: done is high for one cycle with the result on the result port;
// the receiver cannot stall and results leave in input order.
// Depth: set by the divider for num^2/|n|^2 (63 stages, one quotient bit
// each) and the square root after it (32 stages, one root bit each); the
// three displacement divides run beside the first of these.
// Reset clears every stage valid bit, so nothing in flight is delivered.
module point_to_plane_projection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  ptpp_pkg::point_t  point,
	output logic              done,
	output ptpp_pkg::result_t result
);
	import ptpp_pkg::*;

	typedef struct packed {
		logic [2:0][31:0] pv;
		logic [2:0]       sgn;
		logic [2:0]       dovf;
		logic [2:0][66:0] drem;
		logic [2:0][DQ_BITS-1:0] dq;
		logic             sovf;
		logic [95:0]      srem;
		logic [SQ_BITS-1:0] sq;
	} dv_t;

	typedef struct packed {
		logic [2:0][31:0] proj;
		logic             sat;
		logic             dz_pos;
		logic             sovf;
		logic [63:0]      op;
		logic [63:0]      res;
	} sr_t;

	// one quotient bit of each divide; the displacement divides take part only in the first DQ_BITS steps
	function automatic dv_t div_step(input dv_t s, input logic [31:0] nn, input int j);
		dv_t r;
		logic [96:0] sd;
		logic [67:0] dd;
		r = s;
		sd = {1'b0, s.srem} - {1'b0, (96'(nn) << (SQ_BITS - 1 - j))};
		if (!sd[96]) begin
			r.srem = sd[95:0];
			r.sq[SQ_BITS - 1 - j] = 1'b1;
		end
		if (j < DQ_BITS) begin
			for (int i = 0; i < 3; i++) begin
				dd = {1'b0, s.drem[i]} - {1'b0, (67'({nn, 1'b0}) << (DQ_BITS - 1 - j))};
				if (!dd[67]) begin
					r.drem[i] = dd[66:0];
					r.dq[i][DQ_BITS - 1 - j] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// one root bit of the square root
	function automatic sr_t sqrt_step(input sr_t s, input int k);
		sr_t r;
		logic [63:0] one;
		logic [64:0] t;
		r = s;
		one = 64'(1) << (2 * RT_BITS - 2 - 2 * k);
		t = {1'b0, s.op} - {1'b0, (s.res + one)};
		if (!t[64]) begin
			r.op = t[63:0];
			r.res = (s.res >> 1) + one;
		end else begin
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	// configuration registers
	logic signed [15:0] nx_q, ny_q;
	logic [14:0]        nz_q;
	logic signed [31:0] d_q;
	logic [31:0]        nn_q;
	logic               nn_zero_q;

	logic signed [31:0] nx_sq, ny_sq;
	logic [29:0]        nz_sq;

	// pipeline
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][31:0]   pv_s1, pv_s2, pv_s3, pv_s4, pv_s5;
	logic signed [47:0] dx_s1, dy_s1, dz_s1;
	logic signed [49:0] num_s2;
	logic [47:0]        mag_s3;
	logic               neg_s3;
	logic [2:0][63:0]   prod_s4;
	logic [2:0]         sgn_s4, sgn_s5;
	logic [47:0]        hh_s4, hl_s4, ll_s4;
	logic [2:0][66:0]   a_s5;
	logic [95:0]        sq_s5;

	logic [49:0]        num_abs;
	logic [2:0][15:0]   anv;

	dv_t                dv_s [0:SQ_BITS];
	dv_t                dv_n [0:SQ_BITS-1];
	logic [SQ_BITS:0]   dvv_s;
	dv_t                dv_in;

	sr_t                sr_s [0:RT_BITS];
	sr_t                sr_n [0:RT_BITS-1];
	logic [RT_BITS:0]   srv_s;
	sr_t                pj_n;

	logic               done_q;
	result_t            result_q;
	result_t            res_n;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= 15'd16384;
			d_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_NX:  nx_q <= pwdata[15:0];
				REG_NY:  ny_q <= pwdata[15:0];
				REG_NZ:  nz_q <= pwdata[14:0];
				REG_D:   d_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_NX:  prdata = {{16{nx_q[15]}}, nx_q};
			REG_NY:  prdata = {{16{ny_q[15]}}, ny_q};
			REG_NZ:  prdata = {17'd0, nz_q};
			REG_D:   prdata = d_q;
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// track |n|^2 from the registers
	assign nx_sq = nx_q * nx_q;
	assign ny_sq = ny_q * ny_q;
	assign nz_sq = nz_q * nz_q;

	always_ff @(posedge clk) begin
		nn_q      <= $unsigned(nx_sq) + $unsigned(ny_sq) + 32'(nz_sq);
		nn_zero_q <= (nx_q == '0) && (ny_q == '0) && (nz_q == '0);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			dvv_s  <= '0;
			srv_s  <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			dvv_s  <= {dvv_s[SQ_BITS-1:0], v_s5};
			srv_s  <= {srv_s[RT_BITS-1:0], dvv_s[SQ_BITS]};
			done_q <= srv_s[RT_BITS];
		end
	end

	// take the magnitude of num
	assign num_abs = num_s2[49] ? -num_s2 : num_s2;

	// magnitude of each normal component
	assign anv[0] = nx_q[15] ? 16'(-nx_q) : nx_q;
	assign anv[1] = ny_q[15] ? 16'(-ny_q) : ny_q;
	assign anv[2] = {1'b0, nz_q};

	// front stages: dot product, num, magnitude, products, dividends
	always_ff @(posedge clk) begin
		pv_s1[0] <= point.point_x;
		pv_s1[1] <= point.point_y;
		pv_s1[2] <= point.point_z;
		dx_s1    <= nx_q * point.point_x;
		dy_s1    <= ny_q * point.point_y;
		dz_s1    <= $signed({1'b0, nz_q}) * point.point_z;

		pv_s2  <= pv_s1;
		num_s2 <= $signed({{4{d_q[31]}}, d_q, 14'd0})
			- (50'(dx_s1) + 50'(dy_s1) + 50'(dz_s1));

		pv_s3  <= pv_s2;
		mag_s3 <= num_abs[47:0];
		neg_s3 <= num_s2[49];

		pv_s4      <= pv_s3;
		prod_s4[0] <= anv[0] * mag_s3;
		prod_s4[1] <= anv[1] * mag_s3;
		prod_s4[2] <= anv[2] * mag_s3;
		sgn_s4     <= {neg_s3, ny_q[15] ^ neg_s3, nx_q[15] ^ neg_s3};
		hh_s4      <= mag_s3[47:24] * mag_s3[47:24];
		hl_s4      <= mag_s3[47:24] * mag_s3[23:0];
		ll_s4      <= mag_s3[23:0] * mag_s3[23:0];

		pv_s5  <= pv_s4;
		sgn_s5 <= sgn_s4;
		for (int i = 0; i < 3; i++) begin
			a_s5[i] <= 67'({prod_s4[i], 1'b0}) + 67'(nn_q);
		end
		sq_s5 <= {hh_s4, 48'd0} + {23'd0, hl_s4, 25'd0} + {48'd0, ll_s4};
	end

	// range checks that seed the divides
	always_comb begin
		dv_in      = '0;
		dv_in.pv   = pv_s5;
		dv_in.sgn  = sgn_s5;
		dv_in.drem = a_s5;
		dv_in.srem = sq_s5;
		for (int i = 0; i < 3; i++) begin
			dv_in.dovf[i] = a_s5[i] >= (67'({nn_q, 1'b0}) << DQ_BITS);
		end
		dv_in.sovf = sq_s5 >= (96'(nn_q) << SQ_BITS);
	end

	for (genvar j = 0; j < SQ_BITS; j++) begin : g_div
		assign dv_n[j] = div_step(dv_s[j], nn_q, j);
	end

	// divider stages
	always_ff @(posedge clk) begin
		dv_s[0] <= dv_in;
		for (int j = 0; j < SQ_BITS; j++) begin
			dv_s[j+1] <= dv_n[j];
		end
	end

	// apply the displacements and seed the square root
	always_comb begin
		logic [DQ_BITS-1:0] q;
		logic [35:0]        dlt;
		logic [35:0]        sum;
		pj_n = '0;
		for (int i = 0; i < 3; i++) begin
			q   = dv_s[SQ_BITS].dovf[i] ? '1 : dv_s[SQ_BITS].dq[i];
			dlt = dv_s[SQ_BITS].sgn[i] ? -{2'b0, q} : {2'b0, q};
			sum = {{4{dv_s[SQ_BITS].pv[i][31]}}, dv_s[SQ_BITS].pv[i]} + dlt;
			if (!sum[35] && (sum[34:31] != 4'b0000)) begin
				pj_n.proj[i] = 32'h7FFF_FFFF;
				pj_n.sat     = 1'b1;
			end else if (sum[35] && (sum[34:31] != 4'b1111)) begin
				pj_n.proj[i] = 32'h8000_0000;
				pj_n.sat     = 1'b1;
			end else begin
				pj_n.proj[i] = sum[31:0];
			end
		end
		q           = dv_s[SQ_BITS].dovf[2] ? '1 : dv_s[SQ_BITS].dq[2];
		pj_n.dz_pos = !dv_s[SQ_BITS].sgn[2] && (q != '0);
		pj_n.sovf   = dv_s[SQ_BITS].sovf;
		pj_n.op     = {1'b0, dv_s[SQ_BITS].sq};
		pj_n.res    = '0;
	end

	for (genvar k = 0; k < RT_BITS; k++) begin : g_sqrt
		assign sr_n[k] = sqrt_step(sr_s[k], k);
	end

	// square root stages
	always_ff @(posedge clk) begin
		sr_s[0] <= pj_n;
		for (int k = 0; k < RT_BITS; k++) begin
			sr_s[k+1] <= sr_n[k];
		end
	end

	// sign and saturate the distance, build the result beat
	always_comb begin
		logic [31:0] dmag;
		logic        sat;
		dmag = sr_s[RT_BITS].res[31:0];
		sat  = sr_s[RT_BITS].sat;
		res_n = '0;
		res_n.proj_x = sr_s[RT_BITS].proj[0];
		res_n.proj_y = sr_s[RT_BITS].proj[1];
		res_n.proj_z = sr_s[RT_BITS].proj[2];
		if (!sr_s[RT_BITS].dz_pos) begin
			if (sr_s[RT_BITS].sovf || dmag[31]) begin
				res_n.signed_distance = 32'h7FFF_FFFF;
				sat = 1'b1;
			end else begin
				res_n.signed_distance = dmag;
			end
		end else begin
			if (sr_s[RT_BITS].sovf || (dmag > 32'h8000_0000)) begin
				res_n.signed_distance = 32'h8000_0000;
				sat = 1'b1;
			end else begin
				res_n.signed_distance = -dmag;
			end
		end
		res_n.status = sat ? ST_SAT : ST_OK;
		if (nn_zero_q) begin
			res_n.proj_x          = '0;
			res_n.proj_y          = '0;
			res_n.proj_z          = '0;
			res_n.signed_distance = '0;
			res_n.status          = ST_ZERO;
		end
		res_n.out_normal_x = nx_q;
		res_n.out_normal_y = ny_q;
		res_n.out_normal_z = nz_q;
	end

	// output register
	always_ff @(posedge clk) begin
		result_q <= res_n;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
